### sv/lba_pkg.sv
// Shared types, codes and sizes for the LIFO buffer allocator.
package lba_pkg;

   // Pool and stack sizes
   localparam int POOL_BYTES  = 4096;
   localparam int STACK_DEPTH = 64;
   localparam int OFF_W       = 12;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH);
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 6;

   // Offset bit 0 marks a block freed out of order; offsets are 4-byte aligned
   localparam logic [OFF_W-1:0] FREED_MARK  = OFF_W'(1);
   localparam logic [OFF_W-1:0] ALIGN_MASK  = OFF_W'(3);
   localparam logic [OFF_W:0]   BLOCK_EXTRA = (OFF_W+1)'(4);

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_ALLOC      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEPTH_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TOP_FREED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DEFERRED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OFF_W-1:0]  request_size;
      logic [OFF_W-1:0]  block_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    alloc_offset;
      logic [COUNT_W-1:0]  released_count;
      logic [COUNT_W-1:0]  high_water;
   } rsp_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DISPATCH,
      FSM_ALLOC_EVAL,
      FSM_TOP_CHECK,
      FSM_CASC_READ,
      FSM_CASC_EVAL,
      FSM_SCAN_READ,
      FSM_SCAN_EVAL
   } state_type;

   typedef enum logic [1:0] {
      RD_TOP,
      RD_BELOW_TOP,
      RD_SCAN
   } rd_sel_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH,
      OP_POP,
      OP_CASCADE,
      OP_MARK,
      OP_REINIT,
      OP_SCAN_NEXT
   } op_type;

   // Controller to datapath
   typedef struct packed {
      logic                capture;
      logic                rd_en;
      rd_sel_type          rd_sel;
      op_type              op;
      logic                rsp_en;
      logic [STATUS_W-1:0] rsp_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              top_zero;
      logic              pool_over;
      logic              depth_over;
      logic              top_match;
      logic              scan_hit;
      logic              scan_last;
      logic              marked;
   } stat_type;

endpackage

### sv/lba_ctrl.sv
// Request sequencer for the LIFO buffer allocator.
module lba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lba_pkg::stat_type stat,
   output lba_pkg::cmd_type  cmd
);

   lba_pkg::state_type state_ff, state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lba_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != lba_pkg::FSM_IDLE);

   // Decide next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.rd_sel     = lba_pkg::RD_TOP;
      cmd.op         = lba_pkg::OP_NONE;
      cmd.rsp_en     = 1'b0;
      cmd.rsp_status = lba_pkg::ST_INVALID;
      case (state_ff)
         lba_pkg::FSM_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = lba_pkg::FSM_DISPATCH;
            end
         end
         lba_pkg::FSM_DISPATCH: begin
            case (stat.kind)
               lba_pkg::KIND_ALLOC: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = lba_pkg::RD_TOP;
                  state_in   = lba_pkg::FSM_ALLOC_EVAL;
               end
               lba_pkg::KIND_FREE: begin
                  if (stat.top_zero) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = lba_pkg::ST_INVALID;
                     state_in       = lba_pkg::FSM_IDLE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = lba_pkg::RD_BELOW_TOP;
                     state_in   = lba_pkg::FSM_TOP_CHECK;
                  end
               end
               lba_pkg::KIND_REINIT: begin
                  cmd.op         = lba_pkg::OP_REINIT;
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = lba_pkg::ST_ALLOC;
                  state_in       = lba_pkg::FSM_IDLE;
               end
               default: begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = lba_pkg::ST_INVALID;
                  state_in       = lba_pkg::FSM_IDLE;
               end
            endcase
         end
         lba_pkg::FSM_ALLOC_EVAL: begin
            cmd.rsp_en = 1'b1;
            state_in   = lba_pkg::FSM_IDLE;
            if (stat.pool_over) begin
               cmd.rsp_status = lba_pkg::ST_POOL_FULL;
            end else if (stat.depth_over) begin
               cmd.rsp_status = lba_pkg::ST_DEPTH_FULL;
            end else begin
               cmd.op         = lba_pkg::OP_PUSH;
               cmd.rsp_status = lba_pkg::ST_ALLOC;
            end
         end
         lba_pkg::FSM_TOP_CHECK: begin
            if (stat.top_match) begin
               cmd.op   = lba_pkg::OP_POP;
               state_in = lba_pkg::FSM_CASC_READ;
            end else begin
               state_in = lba_pkg::FSM_SCAN_READ;
            end
         end
         lba_pkg::FSM_CASC_READ: begin
            if (stat.top_zero) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = lba_pkg::ST_TOP_FREED;
               state_in       = lba_pkg::FSM_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = lba_pkg::RD_BELOW_TOP;
               state_in   = lba_pkg::FSM_CASC_EVAL;
            end
         end
         lba_pkg::FSM_CASC_EVAL: begin
            if (stat.marked) begin
               cmd.op   = lba_pkg::OP_CASCADE;
               state_in = lba_pkg::FSM_CASC_READ;
            end else begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = lba_pkg::ST_TOP_FREED;
               state_in       = lba_pkg::FSM_IDLE;
            end
         end
         lba_pkg::FSM_SCAN_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lba_pkg::RD_SCAN;
            state_in   = lba_pkg::FSM_SCAN_EVAL;
         end
         lba_pkg::FSM_SCAN_EVAL: begin
            if (stat.scan_hit) begin
               cmd.op         = lba_pkg::OP_MARK;
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = lba_pkg::ST_DEFERRED;
               state_in       = lba_pkg::FSM_IDLE;
            end else if (stat.scan_last) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = lba_pkg::ST_INVALID;
               state_in       = lba_pkg::FSM_IDLE;
            end else begin
               cmd.op   = lba_pkg::OP_SCAN_NEXT;
               state_in = lba_pkg::FSM_SCAN_READ;
            end
         end
         default: begin
            state_in = lba_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

### sv/lba_datapath.sv
// Offset stack memory, depth counters and response register of the allocator.
module lba_datapath (
   input  logic              clock,
   input  logic              reset,
   input  lba_pkg::req_type  req_payload,
   input  lba_pkg::cmd_type  cmd,
   output lba_pkg::stat_type stat,
   output logic              rsp_strobe,
   output lba_pkg::rsp_type  rsp_payload
);

   logic [lba_pkg::OFF_W-1:0]   mem [lba_pkg::STACK_DEPTH];

   lba_pkg::req_type            req_ff;
   logic [lba_pkg::DEPTH_W-1:0] top_ff, top_in;
   logic [lba_pkg::DEPTH_W-1:0] peak_ff, peak_in;
   logic [lba_pkg::DEPTH_W-1:0] scan_ff, scan_in;
   logic [lba_pkg::DEPTH_W-1:0] released_ff, released_in;
   logic                        zero_valid_ff;
   logic                        rd_zero_ff;
   logic [lba_pkg::OFF_W-1:0]   rd_data_ff;
   lba_pkg::rsp_type            rsp_ff;
   logic                        rsp_strobe_ff;

   logic [lba_pkg::DEPTH_W-1:0] rd_addr;
   logic [lba_pkg::DEPTH_W-1:0] top_inc;
   logic [lba_pkg::DEPTH_W-1:0] top_dec;
   logic [lba_pkg::OFF_W-1:0]   entry;
   logic [lba_pkg::OFF_W-1:0]   used;
   logic [lba_pkg::OFF_W:0]     size_round;
   logic [lba_pkg::OFF_W:0]     new_end;
   logic                        wr_en;
   logic [lba_pkg::DEPTH_W-1:0] wr_addr;
   logic [lba_pkg::OFF_W-1:0]   wr_data;

   assign top_inc = top_ff + lba_pkg::DEPTH_W'(1);
   assign top_dec = top_ff - lba_pkg::DEPTH_W'(1);

   // Select the read address
   always_comb begin
      case (cmd.rd_sel)
         lba_pkg::RD_TOP:       rd_addr = top_ff;
         lba_pkg::RD_BELOW_TOP: rd_addr = top_dec;
         lba_pkg::RD_SCAN:      rd_addr = scan_ff;
         default:               rd_addr = top_ff;
      endcase
   end

   // Entry zero reads as zero until first written
   assign entry      = rd_zero_ff ? '0 : rd_data_ff;
   assign used       = entry & ~lba_pkg::ALIGN_MASK;
   assign size_round = {1'b0, req_ff.request_size & ~lba_pkg::ALIGN_MASK}
                       + lba_pkg::BLOCK_EXTRA;
   assign new_end    = {1'b0, used} + size_round;

   // Report conditions to the controller
   always_comb begin
      stat.kind       = req_ff.kind;
      stat.top_zero   = (top_ff == '0);
      stat.pool_over  = (new_end > (lba_pkg::OFF_W+1)'(lba_pkg::POOL_BYTES - 1));
      stat.depth_over = ({1'b0, top_ff} + (lba_pkg::DEPTH_W+1)'(1))
                        > (lba_pkg::DEPTH_W+1)'(lba_pkg::STACK_DEPTH - 1);
      stat.top_match  = (entry == req_ff.block_offset);
      stat.marked     = ((entry & lba_pkg::FREED_MARK) != '0);
      stat.scan_hit   = (entry == req_ff.block_offset) && !stat.marked;
      stat.scan_last  = (scan_ff == top_dec);
   end

   // Apply the commanded operation
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = top_ff;
      wr_data     = '0;
      top_in      = top_ff;
      peak_in     = peak_ff;
      scan_in     = scan_ff;
      released_in = released_ff;
      case (cmd.op)
         lba_pkg::OP_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = top_inc;
            wr_data = new_end[lba_pkg::OFF_W-1:0];
            top_in  = top_inc;
            if (top_inc > peak_ff) begin
               peak_in = top_inc;
            end
         end
         lba_pkg::OP_POP: begin
            top_in = top_dec;
         end
         lba_pkg::OP_CASCADE: begin
            wr_en       = 1'b1;
            wr_addr     = top_dec;
            wr_data     = entry & ~lba_pkg::FREED_MARK;
            top_in      = top_dec;
            released_in = released_ff + lba_pkg::DEPTH_W'(1);
         end
         lba_pkg::OP_MARK: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff;
            wr_data = entry | lba_pkg::FREED_MARK;
         end
         lba_pkg::OP_REINIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '0;
            top_in  = '0;
         end
         lba_pkg::OP_SCAN_NEXT: begin
            scan_in = scan_ff + lba_pkg::DEPTH_W'(1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      if (cmd.capture) begin
         scan_in     = '0;
         released_in = '0;
      end
   end

   // Write and read the offset stack
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_zero_ff <= (rd_addr == '0) && !zero_valid_ff;
      end
   end

   // Advance control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff        <= '0;
         peak_ff       <= '0;
         zero_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         top_ff        <= top_in;
         peak_ff       <= peak_in;
         rsp_strobe_ff <= cmd.rsp_en;
         if (wr_en && (wr_addr == '0)) begin
            zero_valid_ff <= 1'b1;
         end
      end
   end

   // Hold request, scan position, cascade count and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      scan_ff     <= scan_in;
      released_ff <= released_in;
      if (cmd.rsp_en) begin
         rsp_ff.status         <= cmd.rsp_status;
         rsp_ff.alloc_offset   <= (cmd.rsp_status == lba_pkg::ST_ALLOC
                                   && req_ff.kind == lba_pkg::KIND_ALLOC) ? used : '0;
         rsp_ff.released_count <= (cmd.rsp_status == lba_pkg::ST_TOP_FREED)
                                  ? lba_pkg::COUNT_W'(released_in) : '0;
         rsp_ff.high_water     <= lba_pkg::COUNT_W'(peak_in);
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/lifo_buffer_allocator_core.sv
// Top level of the LIFO buffer allocator: sequencer plus offset-stack datapath.
//
//  channel   ports                      handshake
//  request   req_payload, start, busy   taken when start is high and busy is low
//  response  rsp_payload, rsp_strobe    one cycle per request, cannot be held off
//
// A request runs one at a time through the sequencer; each stack memory read takes an
// address state, then a state that uses the registered data. Allocate reads the top
// entry first; reinit, unused kind and empty-stack free respond from dispatch. Free of
// the top block pops it and then each marked block beneath it. Deferred or unmatched
// free scans the stack entries from the bottom up to the one below the top.
// busy drops as the response strobe rises. Reset clears the stack and high-water.
module lifo_buffer_allocator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lba_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output lba_pkg::rsp_type rsp_payload
);

   lba_pkg::cmd_type  cmd;
   lba_pkg::stat_type stat;

   lba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // An accepted request keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   // The response strobe coincides with the return to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   // Offset only on a successful allocation
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status != lba_pkg::ST_ALLOC
      |-> rsp_payload.alloc_offset == '0)
      else $error("offset reported without allocation");

   // Cascade count only on a top free
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status != lba_pkg::ST_TOP_FREED
      |-> rsp_payload.released_count == '0)
      else $error("released count reported without top free");

endmodule

### tb/tb_lifo_buffer_allocator_core.sv
// Self-checking testbench for the LIFO buffer allocator core with a built-in predictor.
module tb_lifo_buffer_allocator_core;
   import lba_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int SETTLE_CYCLES    = 150;
   localparam int MAX_GAP          = 12;
   localparam int RANDOM_PER_PHASE = 420;
   localparam int DIRECTED_ROWS    = 22;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   // Predictor state: block start offsets (bit 0 is the freed mark), depth, peak depth
   logic [OFF_W-1:0]   offset_stack [STACK_DEPTH];
   logic [DEPTH_W-1:0] stack_top = '0;
   logic [DEPTH_W-1:0] peak_depth = '0;

   rsp_type expected_q [$];
   int      fail_count = 0;
   int      quiet_cycles = 0;
   int      sender_idle_pct = 0;
   bit      start_held = 1'b0;

   // Directed requests; expected responses typed in where they follow directly
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{KIND_FREE,   12'd0,    12'd0},    1'b1, '{ST_INVALID,   12'd0, 6'd0, 6'd0}},
      '{'{KIND_UNUSED, 12'd4095, 12'd4095}, 1'b1, '{ST_INVALID,   12'd0, 6'd0, 6'd0}},
      '{'{KIND_REINIT, 12'd4095, 12'd4095}, 1'b1, '{ST_ALLOC,     12'd0, 6'd0, 6'd0}},
      '{'{KIND_ALLOC,  12'd0,    12'd4095}, 1'b1, '{ST_ALLOC,     12'd0, 6'd0, 6'd1}},
      '{'{KIND_ALLOC,  12'd3,    12'd0},    1'b1, '{ST_ALLOC,     12'd4, 6'd0, 6'd2}},
      '{'{KIND_ALLOC,  12'd4095, 12'd0},    1'b1, '{ST_POOL_FULL, 12'd0, 6'd0, 6'd2}},
      '{'{KIND_ALLOC,  12'd4,    12'd0},    1'b0, '0},
      '{'{KIND_ALLOC,  12'd5,    12'd0},    1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd4},    1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd4},    1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd5},    1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd100},  1'b0, '0},
      '{'{KIND_FREE,   12'd4095, 12'd8},    1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd16},   1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd0},    1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd0},    1'b0, '0},
      '{'{KIND_ALLOC,  12'd4091, 12'd0},    1'b0, '0},
      '{'{KIND_ALLOC,  12'd0,    12'd0},    1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd4095}, 1'b0, '0},
      '{'{KIND_REINIT, 12'd0,    12'd0},    1'b0, '0},
      '{'{KIND_ALLOC,  12'd2048, 12'd0},    1'b0, '0},
      '{'{KIND_FREE,   12'd0,    12'd0},    1'b0, '0}
   };

   lifo_buffer_allocator_core uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Drop the top entry and step the depth down
   function automatic void pop_block();
      offset_stack[stack_top] = '0;
      if (stack_top != 0) begin
         stack_top = stack_top - 1'b1;
      end
   endfunction

   // Apply one request to the predictor and return the response it implies
   function automatic rsp_type predict_response(input req_type r);
      rsp_type     rsp;
      int unsigned used;
      int unsigned need;
      int unsigned k;
      bit          found;
      rsp = '0;
      case (r.kind)
         KIND_ALLOC: begin
            used = int'(offset_stack[stack_top] & ~ALIGN_MASK);
            need = int'(r.request_size & ~ALIGN_MASK) + 4;
            if (used + need > POOL_BYTES - 1) begin
               rsp.status = ST_POOL_FULL;
            end else if (int'(stack_top) + 1 > STACK_DEPTH - 1) begin
               rsp.status = ST_DEPTH_FULL;
            end else begin
               stack_top = stack_top + 1'b1;
               if (stack_top > peak_depth) begin
                  peak_depth = stack_top;
               end
               offset_stack[stack_top] = OFF_W'(used + need);
               rsp.status = ST_ALLOC;
               rsp.alloc_offset = OFF_W'(used);
            end
         end
         KIND_FREE: begin
            if (stack_top == 0) begin
               rsp.status = ST_INVALID;
            end else if (offset_stack[stack_top - 1] != r.block_offset) begin
               // Search below the top for an unmarked match and mark it
               found = 1'b0;
               for (k = 0; k < stack_top; k++) begin
                  if (!found && offset_stack[k] == r.block_offset
                      && (offset_stack[k] & FREED_MARK) == '0) begin
                     offset_stack[k] = offset_stack[k] | FREED_MARK;
                     found = 1'b1;
                  end
               end
               rsp.status = found ? ST_DEFERRED : ST_INVALID;
            end else begin
               // Pop the top, then every marked block directly beneath it
               pop_block();
               while (stack_top != 0 && (offset_stack[stack_top - 1] & FREED_MARK) != '0) begin
                  offset_stack[stack_top - 1] = offset_stack[stack_top - 1] & ~FREED_MARK;
                  pop_block();
                  rsp.released_count = rsp.released_count + 1'b1;
               end
               rsp.status = ST_TOP_FREED;
            end
         end
         KIND_REINIT: begin
            stack_top = '0;
            offset_stack[0] = '0;
            rsp.status = ST_ALLOC;
         end
         default: begin
            rsp.status = ST_INVALID;
         end
      endcase
      rsp.high_water = peak_depth;
      return rsp;
   endfunction

   // Hold a request until taken, record its expected response, then idle at random
   task automatic issue_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      req_payload <= r;
      start <= 1'b1;
      start_held = 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      predicted = predict_response(r);
      expected_q.push_back(typed ? want : predicted);
      gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, MAX_GAP) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         start_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every outstanding response has come back
   task automatic wait_for_responses();
      if (start_held) begin
         start <= 1'b0;
         start_held = 1'b0;
         @(posedge clock);
      end
      while (expected_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Build a random request; most frees are aimed at blocks that are live in the predictor
   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      k;
      r.kind = KIND_ALLOC;
      r.request_size = OFF_W'($urandom_range(0, 4095));
      r.block_offset = OFF_W'($urandom_range(0, 4095));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if ($urandom_range(0, 99) < 80) begin
            r.request_size = OFF_W'($urandom_range(0, 63));
         end
      end else if (pick < 80) begin
         r.kind = KIND_FREE;
         if (stack_top != 0) begin
            k = ($urandom_range(0, 99) < 60) ? int'(stack_top) - 1
                                               : $urandom_range(0, int'(stack_top) - 1);
            r.block_offset = offset_stack[k] & ~FREED_MARK;
         end
      end else if (pick < 90) begin
         r.kind = KIND_FREE;
      end else if (pick < 94) begin
         r.kind = KIND_UNUSED;
      end else begin
         r.kind = KIND_REINIT;
      end
      return r;
   endfunction

   // Fill the stack to its depth limit, mark every lower block, then free the top
   task automatic fill_and_unwind();
      int      order [STACK_DEPTH];
      int      n;
      int      i;
      int      j;
      int      tmp;
      req_type r;
      r = '{KIND_REINIT, OFF_W'($urandom_range(0, 4095)), OFF_W'($urandom_range(0, 4095))};
      issue_request(r, 1'b0, '0);
      for (i = 0; i < STACK_DEPTH; i++) begin
         r = '{KIND_ALLOC, OFF_W'($urandom_range(0, 3)), OFF_W'($urandom_range(0, 4095))};
         issue_request(r, 1'b0, '0);
      end
      n = int'(stack_top) - 1;
      for (i = 0; i < n; i++) begin
         order[i] = i;
      end
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (i = 0; i < n; i++) begin
         r = '{KIND_FREE, OFF_W'($urandom_range(0, 4095)), offset_stack[order[i]]};
         issue_request(r, 1'b0, '0);
      end
      r = '{KIND_FREE, OFF_W'($urandom_range(0, 4095)), offset_stack[stack_top - 1]};
      issue_request(r, 1'b0, '0);
   endtask

   // Report one field that differs from its expectation
   function automatic void check_field(input string name, input int want, input int got,
                                       input logic known);
      if (!known || want != got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Compare each response strobe against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response: expected none, actual %h",
                     $time, rsp_payload);
         end else begin
            want = expected_q.pop_front();
            check_field("status", want.status, rsp_payload.status,
                        !$isunknown(rsp_payload.status));
            check_field("alloc_offset", want.alloc_offset, rsp_payload.alloc_offset,
                        !$isunknown(rsp_payload.alloc_offset));
            check_field("released_count", want.released_count, rsp_payload.released_count,
                        !$isunknown(rsp_payload.released_count));
            check_field("high_water", want.high_water, rsp_payload.high_water,
                        !$isunknown(rsp_payload.high_water));
         end
      end
   end

   // End the run when neither a request nor a response moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Reset, directed rows, three fill/unwind and random phases, varied sender idling
   initial begin
      int phase;
      int i;
      for (i = 0; i < STACK_DEPTH; i++) begin
         offset_stack[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 85 : 0;
         if (phase == 0) begin
            for (i = 0; i < DIRECTED_ROWS; i++) begin
               issue_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].want);
            end
         end
         fill_and_unwind();
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            issue_request(random_request(), 1'b0, '0);
         end
         wait_for_responses();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
